/* hw/rtl/asn1_time_decoder_core_defines.svh */
// Assertion macros shared by the decoder modules.
`ifndef ASN1_TIME_DECODER_CORE_DEFINES_SVH
`define ASN1_TIME_DECODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define ASN1T_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

`define ASN1T_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) \
      else $error(msg);

`else

`define ASN1T_ASSERT(name, prop, msg)

`define ASN1T_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

/* hw/rtl/asn1t_pkg.sv */
package asn1t_pkg;

   localparam logic [7:0] TagUtc    = 8'h17;
   localparam logic [7:0] TagGen    = 8'h18;
   localparam logic [7:0] ChDot     = 8'h2E;
   localparam logic [7:0] ChComma   = 8'h2C;
   localparam logic [7:0] ChPlus    = 8'h2B;
   localparam logic [7:0] ChMinus   = 8'h2D;
   localparam logic [7:0] ChZero    = 8'h30;
   localparam logic [7:0] ChNine    = 8'h39;
   localparam logic [7:0] MinLength = 8'd10;

   localparam int QueueDepth = 2;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = $clog2(QueueDepth + 1);

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_TAG   = 2'd1,
      ST_CORRUPT   = 2'd2,
      ST_TRUNCATED = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] data;
      logic [3:0] digit;
      logic       is_digit;
      logic       is_frac_mark;
      logic       is_sign;
      logic       is_minus;
      logic       tag_ok;
      logic       tag_gen;
      logic       start;
      logic       last;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic        is_gen;
      logic [13:0] year;
      logic [6:0]  month;
      logic [7:0]  day;
      logic [7:0]  hour;
      logic [7:0]  minute;
      logic [6:0]  second;
      logic [9:0]  millisecond;
   } result_type;

endpackage

/* hw/rtl/asn1_time_decoder_core.sv */
// Channel  Direction  Transaction content
// req      in         tdata: data_byte; tuser: start_req; tlast: last
// rsp      out        tdata: time fields; tuser: status, is_generalized
// csr      in         wdata: accept_generalized
//
// One byte is accepted every cycle while the queue has room; results leave
// at up to one per cycle. A byte waits in the queue between classifier and
// parser before its result, if any, is written to the output register.
// The parser stalls only when it must produce a result and the output
// register is still occupied and not taken in that cycle; the queue then
// fills and req_tready drops.
// Reset is synchronous and leaves accept_generalized set.
module asn1_time_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   input  logic        req_tlast,
   input  logic [0:0]  req_tuser,  // [0] start_req
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [13:0] year, [20:14] month, [28:21] day, [36:29] hour, [44:37] minute,
   // [51:45] second, [61:52] millisecond, [63:62] zero
   output logic [63:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,  // [1:0] status, [2] is_generalized
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_wdata
);
   import asn1t_pkg::*;

   logic       q_full;
   logic       q_push;
   logic       q_pop;
   logic       q_empty;
   item_type   q_item_in;
   item_type   q_item_out;
   result_type result;

   asn1t_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_item_in)
   );

   asn1t_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .item_in  (q_item_in),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .item_out (q_item_out)
   );

   asn1t_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_item     (q_item_out),
      .q_pop      (q_pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_result (result)
   );

   assign rsp_tdata = {2'b00, result.millisecond, result.second, result.minute,
                       result.hour, result.day, result.month, result.year};
   assign rsp_tuser = {result.is_gen, result.status};

endmodule

/* hw/rtl/asn1t_front.sv */
module asn1t_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic [0:0]         req_tuser,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_wdata,
   input  logic               q_full,
   output logic               q_push,
   output asn1t_pkg::item_type q_item
);
   import asn1t_pkg::*;

   logic accept_gen_ff;
   logic accept_gen_in;

   assign csr_ready     = 1'b1;
   assign accept_gen_in = csr_valid ? csr_wdata[0] : accept_gen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accept_gen_ff <= 1'b1;
      end else begin
         accept_gen_ff <= accept_gen_in;
      end
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_item.data         = req_tdata;
      q_item.is_digit     = (req_tdata >= ChZero) && (req_tdata <= ChNine);
      q_item.digit        = q_item.is_digit ? req_tdata[3:0] : 4'd0;
      q_item.is_frac_mark = (req_tdata == ChDot) || (req_tdata == ChComma);
      q_item.is_sign      = (req_tdata == ChPlus) || (req_tdata == ChMinus);
      q_item.is_minus     = (req_tdata == ChMinus);
      q_item.tag_gen      = (req_tdata == TagGen) && accept_gen_ff;
      q_item.tag_ok       = (req_tdata == TagUtc) || q_item.tag_gen;
      q_item.start        = req_tuser[0];
      q_item.last         = req_tlast;
   end

endmodule

/* hw/rtl/asn1t_queue.sv */
`include "asn1_time_decoder_core_defines.svh"

module asn1t_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  asn1t_pkg::item_type item_in,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output asn1t_pkg::item_type item_out
);
   import asn1t_pkg::*;

   logic [QPtrW-1:0] wr_ff, wr_in;
   logic [QPtrW-1:0] rd_ff, rd_in;
   logic [QCntW-1:0] count_ff, count_in;
   item_type         mem_ff [QueueDepth];

   assign full     = (count_ff == QCntW'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign item_out = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == QPtrW'(QueueDepth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QPtrW'(QueueDepth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= item_in;
      end
   end

   `ASN1T_ASSERT(a_no_overflow, !(push && full), "Push into a full queue.")
   `ASN1T_ASSERT(a_no_underflow, !(pop && empty), "Pop from an empty queue.")
   `ASN1T_ASSERT(a_count_up, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1),
      "Queue count did not follow a lone push.")

endmodule

/* hw/rtl/asn1t_back.sv */
`include "asn1_time_decoder_core_defines.svh"

module asn1t_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  asn1t_pkg::item_type   q_item,
   output logic                  q_pop,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output asn1t_pkg::result_type rsp_result
);
   import asn1t_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_LEN, PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MIN, PH_SEC,
      PH_USEC_A, PH_USEC_B, PH_POST, PH_FRAC, PH_ZONE, PH_OFFH, PH_OFFM, PH_TAIL
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic        gen_ff, gen_in;
   logic [2:0]  digit_idx_ff, digit_idx_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in;
   logic [7:0]  day_ff, day_in;
   logic [7:0]  hour_ff, hour_in;
   logic [7:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic [9:0]  frac_ff, frac_in;
   logic        off_sign_ff, off_sign_in;
   logic [6:0]  off_hours_ff, off_hours_in;
   logic [6:0]  off_min_ff, off_min_in;
   logic        rsp_valid_ff;
   result_type  rsp_ff, rsp_in;

   logic        emit;
   status_type  status;
   logic        dec;
   logic [2:0]  idx_next;
   logic [2:0]  need;
   logic [13:0] year_push;
   logic [6:0]  month_push, second_push, off_hours_push, off_min_push;
   logic [7:0]  day_push, hour_push, minute_push;
   logic [9:0]  frac_push;
   logic [7:0]  h1;
   logic [7:0]  oh8, om8;
   logic        out_free;
   item_type    it;

   assign it          = q_item;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign q_pop       = !q_empty && (out_free || !emit);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_result  = rsp_ff;

   assign year_push      = (year_ff << 3) + (year_ff << 1) + 14'(it.digit);
   assign month_push     = (month_ff << 3) + (month_ff << 1) + 7'(it.digit);
   assign day_push       = (day_ff << 3) + (day_ff << 1) + 8'(it.digit);
   assign hour_push      = (hour_ff << 3) + (hour_ff << 1) + 8'(it.digit);
   assign minute_push    = (minute_ff << 3) + (minute_ff << 1) + 8'(it.digit);
   assign second_push    = (second_ff << 3) + (second_ff << 1) + 7'(it.digit);
   assign frac_push      = (frac_ff << 3) + (frac_ff << 1) + 10'(it.digit);
   assign off_hours_push = (off_hours_ff << 3) + (off_hours_ff << 1) + 7'(it.digit);
   assign off_min_push   = (off_min_ff << 3) + (off_min_ff << 1) + 7'(it.digit);
   assign oh8            = {1'b0, off_hours_ff};
   assign om8            = {1'b0, off_min_push};

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      gen_in       = gen_ff;
      digit_idx_in = digit_idx_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      frac_in      = frac_ff;
      off_sign_in  = off_sign_ff;
      off_hours_in = off_hours_ff;
      off_min_in   = off_min_ff;
      emit         = 1'b0;
      status       = ST_OK;
      dec          = 1'b0;
      idx_next     = digit_idx_ff + 1'b1;
      need         = 3'd2;
      h1           = hour_ff;
      if (phase_ff == PH_YEAR && gen_ff) begin
         need = 3'd4;
      end else if (phase_ff == PH_FRAC) begin
         need = 3'd3;
      end

      if (!q_empty) begin
         if (it.start) begin
            phase_in     = PH_IDLE;
            remaining_in = '0;
            gen_in       = 1'b0;
            digit_idx_in = '0;
            year_in      = '0;
            month_in     = '0;
            day_in       = '0;
            hour_in      = '0;
            minute_in    = '0;
            second_in    = '0;
            frac_in      = '0;
            off_sign_in  = 1'b0;
            off_hours_in = '0;
            off_min_in   = '0;
            if (!it.tag_ok) begin
               emit   = 1'b1;
               status = ST_BAD_TAG;
            end else begin
               gen_in   = it.tag_gen;
               phase_in = PH_LEN;
               if (it.last) begin
                  emit   = 1'b1;
                  status = ST_TRUNCATED;
               end
            end
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_LEN: begin
                  if (it.data < MinLength) begin
                     emit   = 1'b1;
                     status = ST_CORRUPT;
                  end else begin
                     remaining_in = it.data;
                     phase_in     = PH_YEAR;
                     digit_idx_in = '0;
                     if (it.last) begin
                        emit   = 1'b1;
                        status = ST_TRUNCATED;
                     end
                  end
               end
               PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MIN, PH_SEC, PH_FRAC,
               PH_OFFH, PH_OFFM: begin
                  if (!it.is_digit) begin
                     emit   = 1'b1;
                     status = ST_CORRUPT;
                  end else begin
                     unique case (phase_ff)
                        PH_YEAR:  year_in      = year_push;
                        PH_MONTH: month_in     = month_push;
                        PH_DAY:   day_in       = day_push;
                        PH_HOUR:  hour_in      = hour_push;
                        PH_MIN:   minute_in    = minute_push;
                        PH_SEC:   second_in    = second_push;
                        PH_FRAC:  frac_in      = frac_push;
                        PH_OFFH:  off_hours_in = off_hours_push;
                        default:  off_min_in   = off_min_push;
                     endcase
                     if (idx_next < need) begin
                        digit_idx_in = idx_next;
                     end else begin
                        digit_idx_in = '0;
                        unique case (phase_ff)
                           PH_YEAR: begin
                              if (!gen_ff) begin
                                 year_in = year_push +
                                    ((year_push >= 14'd50) ? 14'd1900 : 14'd2000);
                              end
                              phase_in = PH_MONTH;
                           end
                           PH_MONTH: phase_in = PH_DAY;
                           PH_DAY:   phase_in = PH_HOUR;
                           PH_HOUR:  phase_in = PH_MIN;
                           PH_MIN:   phase_in = gen_ff ? PH_SEC : PH_USEC_A;
                           PH_SEC:   phase_in = PH_POST;
                           PH_FRAC:  phase_in = PH_ZONE;
                           PH_OFFH: begin
                              if (off_hours_push >= 7'd24) begin
                                 emit   = 1'b1;
                                 status = ST_CORRUPT;
                              end else begin
                                 phase_in = PH_OFFM;
                              end
                           end
                           default: begin
                              if (off_min_push >= 7'd60) begin
                                 emit   = 1'b1;
                                 status = ST_CORRUPT;
                              end else begin
                                 phase_in = PH_TAIL;
                                 if (!off_sign_ff) begin
                                    hour_in   = hour_ff + oh8;
                                    minute_in = minute_ff + om8;
                                 end else begin
                                    if (oh8 > hour_ff) begin
                                       day_in = day_ff - 1'b1;
                                       h1     = 8'd24 - oh8 + hour_ff;
                                    end else begin
                                       h1 = hour_ff - oh8;
                                    end
                                    if (om8 > minute_ff) begin
                                       hour_in   = h1 - 1'b1;
                                       minute_in = 8'd60 - om8 + minute_ff;
                                    end else begin
                                       hour_in   = h1;
                                       minute_in = minute_ff - om8;
                                    end
                                 end
                              end
                           end
                        endcase
                     end
                     dec = !emit;
                  end
               end
               PH_USEC_A: begin
                  if (it.is_digit) begin
                     second_in = 7'(it.digit);
                     phase_in  = PH_USEC_B;
                  end else begin
                     phase_in = PH_TAIL;
                  end
                  dec = 1'b1;
               end
               PH_USEC_B: begin
                  if (it.is_digit) begin
                     second_in = second_push;
                  end
                  phase_in = PH_TAIL;
                  dec      = 1'b1;
               end
               PH_POST, PH_ZONE: begin
                  if (phase_ff == PH_POST && it.is_frac_mark) begin
                     phase_in     = PH_FRAC;
                     digit_idx_in = '0;
                  end else if (it.is_sign && remaining_ff >= 8'd5) begin
                     off_sign_in  = it.is_minus;
                     phase_in     = PH_OFFH;
                     digit_idx_in = '0;
                  end else begin
                     phase_in = PH_TAIL;
                  end
                  dec = 1'b1;
               end
               PH_TAIL: begin
                  dec = 1'b1;
               end
            endcase
            if (dec) begin
               remaining_in = remaining_ff - 1'b1;
               if (remaining_in == '0) begin
                  emit   = 1'b1;
                  status = ST_OK;
               end else if (it.last) begin
                  emit   = 1'b1;
                  status = ST_TRUNCATED;
               end
            end
         end
      end

      if (emit) begin
         phase_in     = PH_IDLE;
         remaining_in = '0;
      end

      rsp_in = '0;
      rsp_in.status = status;
      if (status == ST_OK) begin
         rsp_in.is_gen      = gen_in;
         rsp_in.year        = year_in;
         rsp_in.month       = month_in;
         rsp_in.day         = day_in;
         rsp_in.hour        = hour_in;
         rsp_in.minute      = minute_in;
         rsp_in.second      = second_in;
         rsp_in.millisecond = frac_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         remaining_ff <= '0;
         gen_ff       <= 1'b0;
         digit_idx_ff <= '0;
         year_ff      <= '0;
         month_ff     <= '0;
         day_ff       <= '0;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         frac_ff      <= '0;
         off_sign_ff  <= 1'b0;
         off_hours_ff <= '0;
         off_min_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            phase_ff     <= phase_in;
            remaining_ff <= remaining_in;
            gen_ff       <= gen_in;
            digit_idx_ff <= digit_idx_in;
            year_ff      <= year_in;
            month_ff     <= month_in;
            day_ff       <= day_in;
            hour_ff      <= hour_in;
            minute_ff    <= minute_in;
            second_ff    <= second_in;
            frac_ff      <= frac_in;
            off_sign_ff  <= off_sign_in;
            off_hours_ff <= off_hours_in;
            off_min_ff   <= off_min_in;
         end
         if (q_pop && emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= rsp_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `ASN1T_ASSERT(a_idle_after_result, (q_pop && emit) |=> (phase_ff == PH_IDLE),
      "Parser not idle after producing a result.")
   `ASN1T_ASSERT(a_result_from_pop, $rose(rsp_valid_ff) |-> $past(q_pop && emit),
      "Result appeared without a consumed item.")
   `ASN1T_ASSERT(a_digit_bound, digit_idx_ff < 3'd4,
      "Digit index ran past the widest field.")

endmodule
